@@ sv/fra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fra_pkg
// Shared widths, request mode codes and the control bundle of the entry row.
// ----------------------------------------------------------------------------
package fra_pkg;

    localparam int ADDR_W = 48;
    localparam int MODE_W = 2;
    localparam int OCC_W  = 4;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic              shift_en;
        logic [ADDR_W-1:0] key;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ sv/fra_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fra_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fra_req_if;
    logic                          valid;
    logic                          ready;
    logic [fra_pkg::MODE_W-1:0]    mode;
    logic [fra_pkg::ADDR_W-1:0]    address;
    logic                          address_present;

    modport source (output valid, output mode, output address, output address_present,
                    input ready);
    modport sink   (input valid, input mode, input address, input address_present,
                    output ready);
endinterface

interface fra_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic                        stored;
    logic [fra_pkg::OCC_W-1:0]   occupied;

    modport source (output valid, output found, output stored, output occupied,
                    input ready);
    modport sink   (input valid, input found, input stored, input occupied,
                    output ready);
endinterface
`default_nettype wire

@@ sv/fifo_replace_address_reject_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// a request is taken in S_IDLE, compared and applied in S_EXEC, and its response registered from there
// requests are not overlapped: a new one is taken only once the entry row's compare-and-update is done
// a response still waiting holds the update step in S_EXEC; no new request is taken meanwhile
// reset: occupancy and handshake state cleared; entry contents undefined, no clearing pass
// ----------------------------------------------------------------------------
// fifo_replace_address_reject_table_unit
// Rejected-address table with oldest-first replacement, built as a shift row
// of entry cells; only the first occupied cells take part in a match.
// ----------------------------------------------------------------------------
module fifo_replace_address_reject_table_unit #(
    parameter int SLOTS = 8
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    fra_req_if.sink   i_req,
    fra_rsp_if.source o_rsp
);
    import fra_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam int OW = (CW > OCC_W) ? CW : OCC_W;
    localparam logic [CW-1:0] FULL = CW'(SLOTS);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state             r_state;
    logic [MODE_W-1:0]  r_mode;
    logic [ADDR_W-1:0]  r_key;
    logic               r_present;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_found;
    logic               r_stored;
    logic [OCC_W-1:0]   r_occ;

    logic [SLOTS-1:0]   hit;
    logic [ADDR_W-1:0]  cell_addr [SLOTS];
    t_cell_ctl          cell_ctl;
    logic               out_free;
    logic               found;
    logic               do_store;
    logic [OW-1:0]      occ_ext;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign found    = r_present && (|hit);
    assign do_store = (r_state == S_EXEC) && out_free && (r_mode == MODE_RECORD)
                      && r_present && !found;

    assign cell_ctl = {do_store, r_key};

    // new entries enter at cell 0, the oldest leaves at the far end
    for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(gi);
        logic [ADDR_W-1:0] prev;
        if (gi == 0) begin : g_head
            assign prev = r_key;
        end else begin : g_link
            assign prev = cell_addr[gi-1];
        end
        fra_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl),
            .i_live (IDX < r_count),
            .i_prev (prev),
            .o_addr (cell_addr[gi]),
            .o_hit  (hit[gi])
        );
    end

    always_comb begin
        n_count = r_count;
        priority if (r_mode == MODE_CLEAR) begin
            n_count = '0;
        end else if (do_store && (r_count != FULL)) begin
            n_count = r_count + CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_rsp.ready;
        if ((r_state == S_EXEC) && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    assign occ_ext = OW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_mode    <= i_req.mode;
                        r_key     <= i_req.address;
                        r_present <= i_req.address_present;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_count     <= n_count;
                        r_found     <= found;
                        r_stored    <= do_store;
                        r_occ       <= occ_ext[OCC_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.found    = r_found;
    assign o_rsp.stored   = r_stored;
    assign o_rsp.occupied = r_occ;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("occupancy above slot count");

    a_store_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.found && o_rsp.stored))
        else $error("stored a request that was already held");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous one in progress");

    a_store_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_store |=> (r_count != '0))
        else $error("store left table empty");

endmodule
`default_nettype wire

@@ sv/fra_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fra_cell
// One table entry: holds an address, compares it with the search key and
// takes its neighbor's address when a new entry is pushed into the row.
// ----------------------------------------------------------------------------
module fra_cell (
    input  wire                        i_clk,
    input  wire fra_pkg::t_cell_ctl    i_ctl,
    input  wire                        i_live,
    input  wire  [fra_pkg::ADDR_W-1:0] i_prev,
    output logic [fra_pkg::ADDR_W-1:0] o_addr,
    output logic                       o_hit
);
    import fra_pkg::*;

    logic [ADDR_W-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            r_addr <= i_prev;
        end
    end

    assign o_addr = r_addr;
    assign o_hit  = i_live && (r_addr == i_ctl.key);

endmodule
`default_nettype wire
